[rtl/assert_macros.svh]
// Shared assertion macros for the convolution core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define SCV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define SCV_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[rtl/scv_pkg.sv]
package scv_pkg;

  localparam int MAX_LINE    = 32;
  localparam int MAX_ROWS    = 32;
  localparam int MAX_KERNEL  = 3;
  localparam int COEF_BITS   = 16;
  localparam int PIXEL_BITS  = 8;

  localparam int SLOT_BITS   = 16;
  localparam int KROW_BITS   = 3 * SLOT_BITS;
  localparam int XW          = $clog2(MAX_LINE);
  localparam int WW          = $clog2(MAX_LINE + 1);
  localparam int YW          = $clog2(MAX_ROWS);
  localparam int STORE_DEPTH = 3 * MAX_LINE;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int SUM_BITS    = 28;
  localparam int IDX_BITS    = 6;
  localparam int POS_BITS    = ((YW > WW) ? YW : WW) + 3;
  localparam int PROD_BITS   = PIXEL_BITS + COEF_BITS + 1;
  localparam int CFG_IDX_BITS = 3;
  localparam int TQ_DEPTH    = 2;
  localparam int TQ_PW       = $clog2(TQ_DEPTH);
  localparam int OQ_DEPTH    = 4;
  localparam int OQ_PW       = $clog2(OQ_DEPTH);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_KROW_A   = 3'd0,
    REG_KROW_B   = 3'd1,
    REG_KROW_C   = 3'd2,
    REG_KH       = 3'd3,
    REG_KW       = 3'd4,
    REG_STEP     = 3'd5,
    REG_PAD      = 3'd6,
    REG_LINE_LEN = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STORE,
    ST_ROWS,
    ST_COLS,
    ST_TAPS,
    ST_W1,
    ST_W2,
    ST_EMIT,
    ST_FIN
  } back_st_t;

  typedef logic signed [POS_BITS-1:0] pos_t;

  typedef struct packed {
    logic [2:0][KROW_BITS-1:0] krow;
    logic [1:0]                kh;
    logic [1:0]                kw;
    logic [2:0]                s;
    logic                      p;
    logic [WW-1:0]             w;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pix;
    logic [XW-1:0]         x;
    logic [YW-1:0]         y;
    logic [1:0]            slot;
    logic                  fin;
  } task_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] sum;
    logic [IDX_BITS-1:0]        row;
    logic [IDX_BITS-1:0]        col;
    logic                       run_end;
    logic                       done;
  } res_t;

endpackage

[rtl/scv_ram.sv]
module scv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/scv_front.sv]
`include "assert_macros.svh"

module scv_front
  import scv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  push,
  input  logic [PIXEL_BITS-1:0] pix,
  input  logic                  fin_in,
  output logic                  full,
  input  logic                  tq_pop,
  output logic                  tq_empty,
  output task_t                 tq_data
);

  logic [XW-1:0]    col_r, col_nxt;
  logic [YW-1:0]    row_r, row_nxt;
  logic [1:0]       slot_r, slot_nxt;
  task_t            q_r [TQ_DEPTH];
  logic [TQ_PW-1:0] wp_r, rp_r;
  logic [TQ_PW:0]   cnt_r;
  logic             acc_in;
  logic [XW-1:0]    x;
  logic             last_col, fin;
  task_t            t_new;

  assign full     = (cnt_r == (TQ_PW+1)'(TQ_DEPTH));
  assign tq_empty = (cnt_r == '0);
  assign tq_data  = q_r[rp_r];
  assign acc_in   = push && !full;

  always_comb begin
    if (WW'(col_r) >= cfg.w) begin
      x = XW'(cfg.w - WW'(1));
    end else begin
      x = col_r;
    end
    last_col = (WW'(x) == cfg.w - WW'(1));
    fin      = fin_in && last_col;
    t_new    = '{pix: pix, x: x, y: row_r, slot: slot_r, fin: fin};
    col_nxt  = col_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    if (acc_in) begin
      if (fin) begin
        col_nxt  = '0;
        row_nxt  = '0;
        slot_nxt = '0;
      end else if (last_col) begin
        col_nxt = '0;
        if (row_r == YW'(MAX_ROWS - 1)) begin
          row_nxt  = '0;
          slot_nxt = '0;
        end else begin
          row_nxt  = row_r + YW'(1);
          slot_nxt = (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
        end
      end else begin
        col_nxt = x + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
      if (acc_in) begin
        wp_r <= wp_r + TQ_PW'(1);
      end
      if (tq_pop) begin
        rp_r <= rp_r + TQ_PW'(1);
      end
      cnt_r <= cnt_r + (TQ_PW+1)'(acc_in) - (TQ_PW+1)'(tq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      q_r[wp_r] <= t_new;
    end
  end

  `SCV_NEVER(a_tq_underflow, tq_pop && tq_empty, "task queue popped while empty")
  `SCV_ASSERT(a_tq_bound, cnt_r <= (TQ_PW+1)'(TQ_DEPTH), "task queue count out of range")

endmodule

[rtl/scv_out_fifo.sv]
`include "assert_macros.svh"

module scv_out_fifo
  import scv_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  res_t wdata,
  output logic q_full,
  input  logic pop,
  output logic empty,
  output res_t rdata
);

  res_t             q_r [OQ_DEPTH];
  logic [OQ_PW-1:0] wp_r, rp_r;
  logic [OQ_PW:0]   cnt_r;
  logic             rd;

  assign q_full = (cnt_r == (OQ_PW+1)'(OQ_DEPTH));
  assign empty  = (cnt_r == '0);
  assign rdata  = q_r[rp_r];
  assign rd     = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + OQ_PW'(1);
      end
      if (rd) begin
        rp_r <= rp_r + OQ_PW'(1);
      end
      cnt_r <= cnt_r + (OQ_PW+1)'(wr) - (OQ_PW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= wdata;
    end
  end

  `SCV_NEVER(a_oq_overflow, wr && q_full, "result written into a full queue")

endmodule

[rtl/scv_back.sv]
module scv_back
  import scv_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  tq_empty,
  input  task_t tq_data,
  output logic  tq_pop,
  input  logic  oq_full,
  output logic  oq_push,
  output res_t  oq_data
);

  localparam pos_t P_ONE  = 1;
  localparam pos_t P_ZERO = 0;

  back_st_t st_r, st_nxt;
  task_t    task_r, task_nxt;
  logic [IDX_BITS-1:0] i_r, i_nxt, j_r, j_nxt;
  pos_t     ly_r, ly_nxt, lx_r, lx_nxt;
  logic [1:0] k_r, k_nxt, l_r, l_nxt;
  logic signed [SUM_BITS-1:0] acc_r, acc_nxt;
  res_t     pend_r, pend_nxt;
  logic     pend_v_r, pend_v_nxt;
  logic     v1_r, v2_r, issue;
  logic signed [COEF_BITS-1:0] c1_r, coef;
  logic signed [PROD_BITS-1:0] prod_r;
  logic [KROW_BITS-1:0] krow_sel;

  pos_t yv, xv, wv, pv, sv, ly0, lx0, ly_cl, trig, yy, xx, dpos, lx_lim;
  logic bottom, row_hit, col_hit, col_stop, tap_v;
  logic [1:0] d2, rslot;
  logic ram_we;
  logic [AW-1:0] waddr, raddr;
  logic [PIXEL_BITS-1:0] rd;

  assign yv  = pos_t'(task_r.y);
  assign xv  = pos_t'(task_r.x);
  assign wv  = pos_t'(cfg.w);
  assign pv  = pos_t'(cfg.p);
  assign sv  = pos_t'(cfg.s);
  assign ly0 = pos_t'(cfg.kh) - P_ONE - pv;
  assign lx0 = pos_t'(cfg.kw) - P_ONE - pv;
  assign lx_lim = wv + pv - P_ONE;

  always_comb begin
    bottom   = (ly_r == yv + P_ONE) && task_r.fin && cfg.p;
    ly_cl    = (ly_r < P_ZERO) ? P_ZERO : ly_r;
    row_hit  = bottom || ((ly_r != yv + P_ONE) && (ly_cl == yv));
    if (lx_r < P_ZERO) begin
      trig = P_ZERO;
    end else if (lx_r > wv - P_ONE) begin
      trig = wv - P_ONE;
    end else begin
      trig = lx_r;
    end
    col_hit  = bottom || (trig == xv);
    col_stop = (lx_r > lx_lim) || (!bottom && (lx_r > xv) && (xv != wv - P_ONE));
    yy    = ly_r - pos_t'(cfg.kh) + P_ONE + pos_t'(k_r);
    xx    = lx_r - pos_t'(cfg.kw) + P_ONE + pos_t'(l_r);
    tap_v = (yy >= P_ZERO) && (yy <= yv) && (xx >= P_ZERO) && (xx < wv);
    dpos  = yv - yy;
    d2    = dpos[1:0];
    rslot = (task_r.slot >= d2) ? task_r.slot - d2 : task_r.slot + 2'd3 - d2;
    raddr = AW'(rslot) * AW'(MAX_LINE) + AW'(xx[XW-1:0]);
    waddr = AW'(task_r.slot) * AW'(MAX_LINE) + AW'(task_r.x);
    krow_sel = cfg.krow[k_r];
    coef  = $signed(krow_sel[l_r*SLOT_BITS +: COEF_BITS]);
  end

  scv_ram #(
    .WIDTH(PIXEL_BITS),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(task_r.pix),
    .raddr(raddr),
    .rdata(rd)
  );

  always_comb begin
    st_nxt     = st_r;
    task_nxt   = task_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    ly_nxt     = ly_r;
    lx_nxt     = lx_r;
    k_nxt      = k_r;
    l_nxt      = l_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    acc_nxt    = v2_r ? acc_r + SUM_BITS'(prod_r) : acc_r;
    issue      = 1'b0;
    tq_pop     = 1'b0;
    ram_we     = 1'b0;
    oq_push    = 1'b0;
    oq_data    = pend_r;
    oq_data.run_end = 1'b0;
    oq_data.done    = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (!tq_empty) begin
          tq_pop   = 1'b1;
          task_nxt = tq_data;
          st_nxt   = ST_STORE;
        end
      end
      ST_STORE: begin
        ram_we = 1'b1;
        i_nxt  = '0;
        ly_nxt = ly0;
        st_nxt = ST_ROWS;
      end
      ST_ROWS: begin
        if (ly_r > yv + P_ONE) begin
          st_nxt = ST_FIN;
        end else if (row_hit) begin
          j_nxt  = '0;
          lx_nxt = lx0;
          st_nxt = ST_COLS;
        end else begin
          i_nxt  = i_r + IDX_BITS'(1);
          ly_nxt = ly_r + sv;
        end
      end
      ST_COLS: begin
        if (col_stop) begin
          i_nxt  = i_r + IDX_BITS'(1);
          ly_nxt = ly_r + sv;
          st_nxt = ST_ROWS;
        end else if (col_hit) begin
          k_nxt   = '0;
          l_nxt   = '0;
          acc_nxt = '0;
          st_nxt  = ST_TAPS;
        end else begin
          j_nxt  = j_r + IDX_BITS'(1);
          lx_nxt = lx_r + sv;
        end
      end
      ST_TAPS: begin
        issue = 1'b1;
        if (l_r == cfg.kw - 2'd1) begin
          l_nxt = '0;
          if (k_r == cfg.kh - 2'd1) begin
            st_nxt = ST_W1;
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end else begin
          l_nxt = l_r + 2'd1;
        end
      end
      ST_W1: begin
        st_nxt = ST_W2;
      end
      ST_W2: begin
        st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!(pend_v_r && oq_full)) begin
          oq_push      = pend_v_r;
          pend_nxt.sum = acc_r;
          pend_nxt.row = i_r;
          pend_nxt.col = j_r;
          pend_v_nxt   = 1'b1;
          j_nxt        = j_r + IDX_BITS'(1);
          lx_nxt       = lx_r + sv;
          st_nxt       = ST_COLS;
        end
      end
      ST_FIN: begin
        if (!pend_v_r) begin
          st_nxt = ST_IDLE;
        end else if (!oq_full) begin
          oq_push         = 1'b1;
          oq_data.run_end = 1'b1;
          oq_data.done    = task_r.fin;
          pend_v_nxt      = 1'b0;
          st_nxt          = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      v1_r     <= issue && tap_v;
      v2_r     <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    task_r <= task_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    ly_r   <= ly_nxt;
    lx_r   <= lx_nxt;
    k_r    <= k_nxt;
    l_r    <= l_nxt;
    acc_r  <= acc_nxt;
    pend_r <= pend_nxt;
    c1_r   <= coef;
    prod_r <= $signed({1'b0, rd}) * c1_r;
  end

endmodule

[rtl/strided_2d_convolution_core.sv]
// An accepted pixel is written to the row store in the cycle after it leaves the task queue.
// Each window then reads its kernel taps in turn, multiplies and accumulates them, and emits the sum.
// Candidate window rows and columns are scanned one per cycle on their counters, pausing for each window.
// A pixel that triggers no window still takes the idle, store, row-scan and finish states.
// Synchronous active-low reset empties queues and resets states, pixel counters, config.
module strided_2d_convolution_core
  import scv_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [PIXEL_BITS-1:0]       in_pixel_value,
  input  logic                        in_final_pixel,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [SUM_BITS-1:0]  out_window_sum,
  output logic [IDX_BITS-1:0]         out_row,
  output logic [IDX_BITS-1:0]         out_col,
  output logic                        out_run_end,
  output logic                        out_image_done,
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [KROW_BITS-1:0]        cfg_data
);

  logic [2:0][KROW_BITS-1:0] krow_r;
  logic [1:0] kh_r, kw_r;
  logic [2:0] step_r;
  logic       pad_r;
  logic [5:0] len_r;
  cfg_t       cfg;
  task_t      tq_data;
  logic       tq_pop, tq_empty, oq_full, oq_push;
  res_t       oq_wdata, oq_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      krow_r <= '0;
      kh_r   <= 2'd3;
      kw_r   <= 2'd3;
      step_r <= 3'd1;
      pad_r  <= 1'b0;
      len_r  <= 6'd32;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_KROW_A:   krow_r[0] <= cfg_data;
        REG_KROW_B:   krow_r[1] <= cfg_data;
        REG_KROW_C:   krow_r[2] <= cfg_data;
        REG_KH:       kh_r      <= cfg_data[1:0];
        REG_KW:       kw_r      <= cfg_data[1:0];
        REG_STEP:     step_r    <= cfg_data[2:0];
        REG_PAD:      pad_r     <= cfg_data[0];
        REG_LINE_LEN: len_r     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.krow = krow_r;
    if (kh_r == 2'd0) begin
      cfg.kh = 2'd1;
    end else if (kh_r > 2'(MAX_KERNEL)) begin
      cfg.kh = 2'(MAX_KERNEL);
    end else begin
      cfg.kh = kh_r;
    end
    if (kw_r == 2'd0) begin
      cfg.kw = 2'd1;
    end else if (kw_r > 2'(MAX_KERNEL)) begin
      cfg.kw = 2'(MAX_KERNEL);
    end else begin
      cfg.kw = kw_r;
    end
    cfg.s = (step_r == 3'd0) ? 3'd1 : step_r;
    cfg.p = pad_r;
    if (len_r == 6'd0) begin
      cfg.w = WW'(1);
    end else if (7'(len_r) > 7'(MAX_LINE)) begin
      cfg.w = WW'(MAX_LINE);
    end else begin
      cfg.w = WW'(len_r);
    end
  end

  scv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .push    (push),
    .pix     (in_pixel_value),
    .fin_in  (in_final_pixel),
    .full    (full),
    .tq_pop  (tq_pop),
    .tq_empty(tq_empty),
    .tq_data (tq_data)
  );

  scv_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .tq_empty(tq_empty),
    .tq_data (tq_data),
    .tq_pop  (tq_pop),
    .oq_full (oq_full),
    .oq_push (oq_push),
    .oq_data (oq_wdata)
  );

  scv_out_fifo u_oq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (oq_push),
    .wdata (oq_wdata),
    .q_full(oq_full),
    .pop   (pop),
    .empty (empty),
    .rdata (oq_rdata)
  );

  assign out_window_sum = oq_rdata.sum;
  assign out_row        = oq_rdata.row;
  assign out_col        = oq_rdata.col;
  assign out_run_end    = oq_rdata.run_end;
  assign out_image_done = oq_rdata.done;

endmodule

[tb/conv_window_checker.sv]
`timescale 1ns / 1ps

module conv_window_checker
  import scv_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic                       full,
  input  logic [PIXEL_BITS-1:0]      in_pixel_value,
  input  logic                       in_final_pixel,
  input  logic                       empty,
  input  logic                       pop,
  input  logic signed [SUM_BITS-1:0] out_window_sum,
  input  logic [IDX_BITS-1:0]        out_row,
  input  logic [IDX_BITS-1:0]        out_col,
  input  logic                       out_run_end,
  input  logic                       out_image_done,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [KROW_BITS-1:0]       cfg_data,
  output int                         fail_count,
  output int                         windows_pending
);

  logic [KROW_BITS-1:0]   kern_row [3];
  logic [1:0]             kern_h, kern_w;
  logic [2:0]             stride;
  logic                   pad;
  logic [5:0]             width_reg;
  logic [PIXEL_BITS-1:0]  line_buf [STORE_DEPTH];
  int                     col_pos, row_pos;
  res_t                   window_q [$];

  initial begin
    fail_count = 0;
    windows_pending = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic longint tap_coef(input int k, input int l);
    logic signed [15:0] c;
    c = kern_row[k][16*l +: 16];
    return longint'(c);
  endfunction

  task automatic predict_windows(input logic [PIXEL_BITS-1:0] pix, input logic fin);
    int kh, kw, s, p, w, x, y, i, j, k, l, ly, lx, trig, yy, xx;
    bit last_col, last_pix, bottom;
    longint acc;
    res_t r;
    res_t batch [$];
    kh = (kern_h == 0) ? 1 : kern_h;
    kw = (kern_w == 0) ? 1 : kern_w;
    s  = (stride == 0) ? 1 : stride;
    p  = pad;
    w  = (width_reg < 1) ? 1 : (width_reg > MAX_LINE) ? MAX_LINE : width_reg;
    x  = (col_pos >= w) ? w - 1 : col_pos;
    y  = row_pos;
    last_col = (x == w - 1);
    last_pix = fin && last_col;
    line_buf[(y % 3) * MAX_LINE + x] = pix;
    for (i = 0; i * s + kh - 1 - p <= y + 1; i++) begin
      ly = i * s + kh - 1 - p;
      bottom = (ly == y + 1);
      if (bottom && !(last_pix && p == 1)) continue;
      if (!bottom && ((ly < 0) ? 0 : ly) != y) continue;
      for (j = 0; j * s + kw <= w + 2 * p; j++) begin
        lx = j * s + kw - 1 - p;
        trig = (lx < 0) ? 0 : (lx > w - 1) ? w - 1 : lx;
        if (!bottom && trig != x) continue;
        if (batch.size() >= 40) continue;
        acc = 0;
        for (k = 0; k < kh; k++) begin
          yy = i * s + k - p;
          if (yy < 0 || yy >= y + 1) continue;
          for (l = 0; l < kw; l++) begin
            xx = j * s + l - p;
            if (xx < 0 || xx >= w) continue;
            acc += longint'(line_buf[(yy % 3) * MAX_LINE + xx]) * tap_coef(k, l);
          end
        end
        r.sum = acc[SUM_BITS-1:0];
        r.row = i[IDX_BITS-1:0];
        r.col = j[IDX_BITS-1:0];
        r.run_end = 1'b0;
        r.done = 1'b0;
        batch.push_back(r);
      end
    end
    if (batch.size() > 0) begin
      batch[batch.size()-1].run_end = 1'b1;
      batch[batch.size()-1].done = last_pix;
    end
    foreach (batch[n]) window_q.push_back(batch[n]);
    if (last_pix) begin
      col_pos = 0;
      row_pos = 0;
    end else if (last_col) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= MAX_ROWS) ? 0 : row_pos + 1;
    end else begin
      col_pos = x + 1;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      kern_row[0] <= '0;
      kern_row[1] <= '0;
      kern_row[2] <= '0;
      kern_h <= 2'd3;
      kern_w <= 2'd3;
      stride <= 3'd1;
      pad <= 1'b0;
      width_reg <= 6'd32;
      col_pos = 0;
      row_pos = 0;
      window_q.delete();
    end else begin
      if (push && !full) predict_windows(in_pixel_value, in_final_pixel);
      if (pop && !empty) begin
        if (window_q.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = window_q.pop_front();
          if (out_window_sum !== want.sum) report_mismatch("window_sum", out_window_sum, want.sum);
          if (out_row !== want.row) report_mismatch("out_row", out_row, want.row);
          if (out_col !== want.col) report_mismatch("out_col", out_col, want.col);
          if (out_run_end !== want.run_end) report_mismatch("run_end", out_run_end, want.run_end);
          if (out_image_done !== want.done) report_mismatch("image_done", out_image_done, want.done);
        end
      end
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_KROW_A:   kern_row[0] <= cfg_data;
          REG_KROW_B:   kern_row[1] <= cfg_data;
          REG_KROW_C:   kern_row[2] <= cfg_data;
          REG_KH:       kern_h <= cfg_data[1:0];
          REG_KW:       kern_w <= cfg_data[1:0];
          REG_STEP:     stride <= cfg_data[2:0];
          REG_PAD:      pad <= cfg_data[0];
          REG_LINE_LEN: width_reg <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
    windows_pending = window_q.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import scv_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [PIXEL_BITS-1:0] in_pixel_value = '0;
  logic in_final_pixel = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [SUM_BITS-1:0] out_window_sum;
  logic [IDX_BITS-1:0] out_row, out_col;
  logic out_run_end, out_image_done;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [KROW_BITS-1:0] cfg_data = '0;

  int fail_count, windows_pending;
  int pixels_sent = 0;
  int idle_cycles = 0;
  int pop_stall = 0;
  bit quiet = 1'b0;

  always #5 clk = ~clk;

  strided_2d_convolution_core dut (.*);

  conv_window_checker checker_i (.*);

  always @(negedge clk) begin
    if (quiet) begin
      pop <= 1'b1;
    end else if (pop_stall > 0) begin
      pop_stall <= pop_stall - 1;
      pop <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      pop_stall <= $urandom_range(0, 14);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || cfg_wr_en || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [PIXEL_BITS-1:0] v, input logic f);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    push <= 1'b1;
    in_pixel_value <= v;
    in_final_pixel <= f;
    do @(posedge clk); while (full);
    pixels_sent++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [KROW_BITS-1:0] v);
    @(negedge clk);
    push <= 1'b0;
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  task automatic load_setup(input logic [KROW_BITS-1:0] ka, kb, kc, input int kh, kw, s, p,
                            input int len);
    write_reg(REG_KROW_A, ka);
    write_reg(REG_KROW_B, kb);
    write_reg(REG_KROW_C, kc);
    write_reg(REG_KH, kh);
    write_reg(REG_KW, kw);
    write_reg(REG_STEP, s);
    write_reg(REG_PAD, p);
    write_reg(REG_LINE_LEN, len);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // The block may still be scanning after the last window has left.
  task automatic drain;
    @(negedge clk);
    push <= 1'b0;
    wait (windows_pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Stray final marks away from the last column must be ignored by the block.
  task automatic send_image(input int len, input int rows, input bit fixed_val,
                            input logic [PIXEL_BITS-1:0] v);
    int w, r, c;
    logic f;
    w = (len < 1) ? 1 : (len > MAX_LINE) ? MAX_LINE : len;
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < w; c++) begin
        if (c == w - 1) f = (r == rows - 1);
        else f = ($urandom_range(0, 9) == 0);
        send_pixel(fixed_val ? v : PIXEL_BITS'($urandom), f);
      end
    end
  endtask

  function automatic logic [KROW_BITS-1:0] rand_row();
    logic [KROW_BITS-1:0] k;
    int l;
    k = {$urandom, $urandom};
    for (l = 0; l < 3; l++) begin
      case ($urandom_range(0, 5))
        0: k[16*l +: 16] = 16'h8000;
        1: k[16*l +: 16] = 16'h7fff;
        2: k[16*l +: 16] = 16'h1000;
        default: ;
      endcase
    end
    return k;
  endfunction

  initial begin
    int len, rows, w;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    load_setup({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}}, 3, 3, 1, 1, 3);
    send_image(3, 3, 1'b1, 8'hff);
    drain();
    load_setup({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 0, 0, 0, 0, 0);
    send_image(0, 2, 1'b1, 8'hff);
    send_image(0, 1, 1'b1, 8'h00);
    drain();
    load_setup('1, '0, {3{16'h1000}}, 3, 3, 7, 0, 2);
    send_image(2, 2, 1'b0, 8'h00);
    drain();
    load_setup(rand_row(), rand_row(), rand_row(), 2, 1, 5, 1, 40);
    send_image(40, 1, 1'b0, 8'h00);
    drain();

    while (pixels_sent < 300) begin
      if (pixels_sent > 255) quiet = 1'b1;
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 8);
      w = (len < 1) ? 1 : (len > MAX_LINE) ? MAX_LINE : len;
      rows = (w > 8) ? $urandom_range(1, 3) : $urandom_range(1, 6);
      if (w == 1 && $urandom_range(0, 3) == 0) rows = $urandom_range(30, 36);
      load_setup(rand_row(), rand_row(), rand_row(), $urandom_range(0, 3),
                 $urandom_range(0, 3),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 3),
                 $urandom_range(0, 1), len);
      send_image(len, rows, 1'b0, 8'h00);
      drain();
    end

    @(negedge clk);
    push <= 1'b0;
    drain();
    if (fail_count == 0 && windows_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/scv_pkg.sv
rtl/scv_ram.sv
rtl/scv_front.sv
rtl/scv_out_fifo.sv
rtl/scv_back.sv
rtl/strided_2d_convolution_core.sv
tb/conv_window_checker.sv
tb/testbench.sv
